/* design/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU with float conversion.
// Holds the word widths, the fixed-point format and the opcode encoding.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fpa_pkg;

   localparam int INT_BITS   = 15;
   localparam int FRAC_BITS  = 16;
   localparam int TOTAL_BITS = 32;
   localparam int SIGN_POS   = INT_BITS + FRAC_BITS;

   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 3;

   // Single-precision float layout.
   localparam int FLT_MANT = 23;
   localparam int FLT_EXP  = 8;
   localparam logic [FLT_EXP-1:0] FLT_BIAS = 8'd127;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NEG        = 3'd0,
      OP_ABS        = 3'd1,
      OP_ADD        = 3'd2,
      OP_MUL        = 3'd3,
      OP_FROM_FLOAT = 3'd4,
      OP_TO_FLOAT   = 3'd5
   } op_type;

endpackage

/* design/fpa_req_if.sv */
// Request channel of the fixed-point ALU: valid/ready plus opcode and operands.
// Depends on fpa_pkg for the field widths.
interface fpa_req_if;
   logic                             valid;
   logic                             ready;
   logic [fpa_pkg::OPCODE_W-1:0]     opcode;
   logic [fpa_pkg::WORD_W-1:0]       operand_a;
   logic [fpa_pkg::WORD_W-1:0]       operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   output ready);
endinterface

/* design/fpa_rsp_if.sv */
// Response channel of the fixed-point ALU: valid/ready plus result word and sign flag.
// Depends on fpa_pkg for the field widths.
interface fpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fpa_pkg::WORD_W-1:0]   result;
   logic                         sign_of_a;

   modport source (output valid, output result, output sign_of_a, input ready);
   modport sink   (input valid, input result, input sign_of_a, output ready);
endinterface

/* design/fpa_arith.sv */
// Fixed-point arithmetic: negate, absolute value, wrapping add and multiply.
// Purely combinational; depends on fpa_pkg for the format constants.
module fpa_arith (
   input  logic [fpa_pkg::WORD_W-1:0] operand_a,
   input  logic [fpa_pkg::WORD_W-1:0] operand_b,
   output logic [fpa_pkg::WORD_W-1:0] neg_res,
   output logic [fpa_pkg::WORD_W-1:0] abs_res,
   output logic [fpa_pkg::WORD_W-1:0] add_res,
   output logic [fpa_pkg::WORD_W-1:0] mul_res
);

   logic                             sign_a;
   logic                             sign_b;
   logic [fpa_pkg::WORD_W-1:0]       mag_b;
   logic [2*fpa_pkg::WORD_W-1:0]     product;
   logic [fpa_pkg::WORD_W-1:0]       prod_q;

   always_comb begin
      sign_a  = operand_a[fpa_pkg::SIGN_POS];
      sign_b  = operand_b[fpa_pkg::SIGN_POS];
      neg_res = ~operand_a + fpa_pkg::WORD_W'(1);
      abs_res = sign_a ? neg_res : operand_a;
      mag_b   = sign_b ? (~operand_b + fpa_pkg::WORD_W'(1)) : operand_b;
      add_res = operand_a + operand_b;
      // The most negative word keeps its bit pattern under abs, which as an
      // unsigned magnitude is exactly right for the product.
      product = (2*fpa_pkg::WORD_W)'(abs_res) * (2*fpa_pkg::WORD_W)'(mag_b);
      prod_q  = product[fpa_pkg::FRAC_BITS +: fpa_pkg::WORD_W];
      mul_res = (sign_a ^ sign_b) ? (~prod_q + fpa_pkg::WORD_W'(1)) : prod_q;
   end

endmodule

/* design/fpa_conv.sv */
// Conversions between IEEE single-precision bits and the fixed-point word.
// Purely combinational; depends on fpa_pkg for the format constants.
module fpa_conv (
   input  logic [fpa_pkg::WORD_W-1:0] operand_a,
   output logic [fpa_pkg::WORD_W-1:0] from_float_res,
   output logic [fpa_pkg::WORD_W-1:0] to_float_res
);

   logic [fpa_pkg::FLT_EXP-1:0]   f_exp;
   logic [fpa_pkg::FRAC_BITS:0]   fx_base;
   logic [fpa_pkg::FLT_EXP-1:0]   lshift;
   logic [fpa_pkg::FLT_EXP-1:0]   rshift;
   logic [fpa_pkg::WORD_W-1:0]    fx_shifted;

   logic                          sign_a;
   logic [fpa_pkg::WORD_W-1:0]    mag;
   logic [fpa_pkg::WORD_W-1:0]    norm;
   logic [4:0]                    lead_zeros;
   logic [fpa_pkg::FLT_EXP-1:0]   t_exp;

   always_comb begin
      // Float to fixed: hidden one at the binary point, mantissa truncated to
      // the fraction width, then shifted by the unbiased exponent.
      f_exp   = operand_a[fpa_pkg::FLT_MANT +: fpa_pkg::FLT_EXP];
      fx_base = {1'b1, operand_a[fpa_pkg::FLT_MANT-1 -: fpa_pkg::FRAC_BITS]};
      lshift  = f_exp - fpa_pkg::FLT_BIAS;
      rshift  = fpa_pkg::FLT_BIAS - f_exp;
      if (f_exp >= fpa_pkg::FLT_BIAS) begin
         fx_shifted = (lshift < 8'd32) ?
                      (fpa_pkg::WORD_W'(fx_base) << lshift[4:0]) : '0;
      end else begin
         fx_shifted = (rshift < 8'd32) ?
                      (fpa_pkg::WORD_W'(fx_base) >> rshift[4:0]) : '0;
      end
      from_float_res = operand_a[fpa_pkg::WORD_W-1] ?
                       (~fx_shifted + fpa_pkg::WORD_W'(1)) : fx_shifted;

      // Fixed to float: normalize the magnitude in five binary steps so the
      // leading one lands in the top bit; the bits below it form the mantissa.
      sign_a     = operand_a[fpa_pkg::SIGN_POS];
      mag        = sign_a ? (~operand_a + fpa_pkg::WORD_W'(1)) : operand_a;
      norm       = mag;
      lead_zeros = '0;
      if (norm[31:16] == '0) begin
         norm = norm << 16;
         lead_zeros[4] = 1'b1;
      end
      if (norm[31:24] == '0) begin
         norm = norm << 8;
         lead_zeros[3] = 1'b1;
      end
      if (norm[31:28] == '0) begin
         norm = norm << 4;
         lead_zeros[2] = 1'b1;
      end
      if (norm[31:30] == '0) begin
         norm = norm << 2;
         lead_zeros[1] = 1'b1;
      end
      if (!norm[31]) begin
         norm = norm << 1;
         lead_zeros[0] = 1'b1;
      end
      // Exponent is (31 - lead_zeros) - FRAC_BITS + bias, modulo 256.
      t_exp = 8'(31 - fpa_pkg::FRAC_BITS) + fpa_pkg::FLT_BIAS
              - fpa_pkg::FLT_EXP'(lead_zeros);
      if (mag == '0) begin
         to_float_res = '0;
      end else begin
         to_float_res = {sign_a, t_exp,
                         norm[fpa_pkg::WORD_W-2 -: fpa_pkg::FLT_MANT]};
      end
   end

endmodule

/* design/fixed_point_alu_with_float_convert.sv */
// Top level of the fixed-point ALU with float conversion.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_arith and fpa_conv.
//
//   Channel  Dir  Fields                          Handshake
//   req_ch   in   opcode, operand_a, operand_b    valid/ready
//   rsp_ch   out  result, sign_of_a               valid/ready
//
// An item is captured in the input register, passes through the arithmetic
// into the result register, and its result is offered from there until the
// result side takes it.
// One item is accepted every cycle while the result side keeps taking items.
// A stalled result holds in its register; the input register still fills, so
// two items are held before req_ch.ready drops. Synchronous reset empties both.
module fixed_point_alu_with_float_convert (
   input  logic             clock,
   input  logic             reset,
   fpa_req_if.sink          req_ch,
   fpa_rsp_if.source        rsp_ch
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [fpa_pkg::OPCODE_W-1:0]      in_opcode_ff;
   logic [fpa_pkg::WORD_W-1:0]        in_a_ff;
   logic [fpa_pkg::WORD_W-1:0]        in_b_ff;

   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [fpa_pkg::WORD_W-1:0]        out_result_ff;
   logic [fpa_pkg::WORD_W-1:0]        out_result_in;
   logic                              out_sign_ff;

   logic                              advance;

   logic [fpa_pkg::WORD_W-1:0]        neg_res;
   logic [fpa_pkg::WORD_W-1:0]        abs_res;
   logic [fpa_pkg::WORD_W-1:0]        add_res;
   logic [fpa_pkg::WORD_W-1:0]        mul_res;
   logic [fpa_pkg::WORD_W-1:0]        from_float_res;
   logic [fpa_pkg::WORD_W-1:0]        to_float_res;

   fpa_arith u_arith (
      .operand_a (in_a_ff),
      .operand_b (in_b_ff),
      .neg_res   (neg_res),
      .abs_res   (abs_res),
      .add_res   (add_res),
      .mul_res   (mul_res)
   );

   fpa_conv u_conv (
      .operand_a      (in_a_ff),
      .from_float_res (from_float_res),
      .to_float_res   (to_float_res)
   );

   always_comb begin
      advance      = !out_valid_ff || rsp_ch.ready;
      req_ch.ready = !in_valid_ff || advance;
      in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;

      case (fpa_pkg::op_type'(in_opcode_ff))
         fpa_pkg::OP_NEG:        out_result_in = neg_res;
         fpa_pkg::OP_ABS:        out_result_in = abs_res;
         fpa_pkg::OP_ADD:        out_result_in = add_res;
         fpa_pkg::OP_MUL:        out_result_in = mul_res;
         fpa_pkg::OP_FROM_FLOAT: out_result_in = from_float_res;
         fpa_pkg::OP_TO_FLOAT:   out_result_in = to_float_res;
         default:                out_result_in = '0;
      endcase

      rsp_ch.valid     = out_valid_ff;
      rsp_ch.result    = out_result_ff;
      rsp_ch.sign_of_a = out_sign_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_opcode_ff <= req_ch.opcode;
         in_a_ff      <= req_ch.operand_a;
         in_b_ff      <= req_ch.operand_b;
      end
      if (advance && in_valid_ff) begin
         out_result_ff <= out_result_in;
         out_sign_ff   <= in_a_ff[fpa_pkg::SIGN_POS];
      end
   end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the fixed-point ALU with float conversion.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if and the block's top level; a
// scoreboard class predicts each result word and sign flag and compares them.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_CODES = 2 ** fpa_pkg::OPCODE_W;
   localparam logic [fpa_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [fpa_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 530;
   localparam int PRESSURE_AT = 150;
   localparam int QUIET_FROM = 400;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [fpa_pkg::OPCODE_W-1:0] opcode;
      fpa_pkg::word_type            result;
      logic                         sign_of_a;
   } expected_rsp_type;

   class alu_scoreboard;
      localparam fpa_pkg::word_type WORD_MASK =
         (fpa_pkg::TOTAL_BITS >= 32) ? '1 :
         fpa_pkg::word_type'((64'd1 << fpa_pkg::TOTAL_BITS) - 64'd1);
      localparam fpa_pkg::word_type MANT_MASK =
         (fpa_pkg::word_type'(1) << fpa_pkg::FLT_MANT) - 1;

      expected_rsp_type pending_q[$];
      int               compared;
      int               mismatches;
      int               items_seen;
      int               op_count[OP_CODES];

      function logic sign_of(fpa_pkg::word_type v);
         return (fpa_pkg::SIGN_POS < 32) ? logic'((v >> fpa_pkg::SIGN_POS) & 1) : 1'b0;
      endfunction

      function fpa_pkg::word_type negate(fpa_pkg::word_type v);
         return (~v + 1) & WORD_MASK;
      endfunction

      function fpa_pkg::word_type magnitude(fpa_pkg::word_type v);
         return sign_of(v) ? negate(v) : v;
      endfunction

      // Shifts of 32 or more, or negative ones, give zero.
      function fpa_pkg::word_type shift_up(fpa_pkg::word_type v, int s);
         return (s < 0 || s >= 32) ? '0 : v << s;
      endfunction

      function fpa_pkg::word_type shift_down(fpa_pkg::word_type v, int s);
         return (s < 0 || s >= 32) ? '0 : v >> s;
      endfunction

      function fpa_pkg::word_type multiply(fpa_pkg::word_type a, fpa_pkg::word_type b);
         logic [63:0]       product;
         fpa_pkg::word_type r;
         product = {32'b0, magnitude(a)} * {32'b0, magnitude(b)};
         r = fpa_pkg::word_type'(product >> fpa_pkg::FRAC_BITS);
         if (sign_of(a) ^ sign_of(b)) r = negate(r);
         return r;
      endfunction

      function fpa_pkg::word_type float_to_fixed(fpa_pkg::word_type bits);
         fpa_pkg::word_type mant;
         fpa_pkg::word_type fx;
         int                e;
         mant = bits & MANT_MASK;
         e = int'(bits[30:23]) - int'(fpa_pkg::FLT_BIAS);
         fx = shift_up(1, fpa_pkg::FRAC_BITS);
         if (fpa_pkg::FRAC_BITS >= fpa_pkg::FLT_MANT)
            fx |= shift_up(mant, fpa_pkg::FRAC_BITS - fpa_pkg::FLT_MANT);
         else
            fx |= shift_down(mant, fpa_pkg::FLT_MANT - fpa_pkg::FRAC_BITS);
         fx = (e >= 0) ? shift_up(fx, e) : shift_down(fx, -e);
         if (bits[31]) fx = negate(fx);
         return fx;
      endfunction

      function fpa_pkg::word_type fixed_to_float(fpa_pkg::word_type v);
         fpa_pkg::word_type m;
         fpa_pkg::word_type rest;
         fpa_pkg::word_type mant;
         int                pos;
         int                expo;
         if (v == 0) return '0;
         m = magnitude(v);
         if (m == 0) return '0;
         pos = 31;
         while (m[pos] == 1'b0) pos--;
         rest = m & ~shift_up(1, pos);
         mant = (pos <= fpa_pkg::FLT_MANT) ? shift_up(rest, fpa_pkg::FLT_MANT - pos)
                                           : shift_down(rest, pos - fpa_pkg::FLT_MANT);
         expo = (pos - fpa_pkg::FRAC_BITS + int'(fpa_pkg::FLT_BIAS)) & 255;
         return (fpa_pkg::word_type'(sign_of(v)) << 31)
                | (fpa_pkg::word_type'(expo) << fpa_pkg::FLT_MANT)
                | (mant & MANT_MASK);
      endfunction

      function fpa_pkg::word_type alu_result(logic [fpa_pkg::OPCODE_W-1:0] op,
                                             fpa_pkg::word_type a, fpa_pkg::word_type b);
         fpa_pkg::word_type r;
         case (op)
            fpa_pkg::OP_NEG:        r = negate(a);
            fpa_pkg::OP_ABS:        r = magnitude(a);
            fpa_pkg::OP_ADD:        r = a + b;
            fpa_pkg::OP_MUL:        r = multiply(a, b);
            fpa_pkg::OP_FROM_FLOAT: r = float_to_fixed(a);
            fpa_pkg::OP_TO_FLOAT:   r = fixed_to_float(a);
            default:                r = '0;
         endcase
         return r & WORD_MASK;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
      endfunction

      function void note_request(logic [fpa_pkg::OPCODE_W-1:0] op, fpa_pkg::word_type a,
                                 fpa_pkg::word_type b);
         expected_rsp_type e;
         e.opcode = op;
         e.result = alu_result(op, a, b);
         e.sign_of_a = sign_of(a);
         pending_q.push_back(e);
         items_seen++;
         op_count[op]++;
      endfunction

      function void check_response(fpa_pkg::word_type result, logic sign_a);
         expected_rsp_type e;
         if (pending_q.size() == 0) begin
            flag($sformatf("result %h arrived with no item outstanding", result));
            return;
         end
         e = pending_q.pop_front();
         compared++;
         if (result !== e.result)
            flag($sformatf("opcode %0d result: expected %h, got %h",
                           e.opcode, e.result, result));
         if (sign_a !== e.sign_of_a)
            flag($sformatf("opcode %0d sign_of_a: expected %b, got %b",
                           e.opcode, e.sign_of_a, sign_a));
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic idling;
   logic hold_request;
   int   idle_cycles;
   alu_scoreboard board;

   fpa_req_if req_ch();
   fpa_rsp_if rsp_ch();

   fixed_point_alu_with_float_convert DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // Both channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.opcode, req_ch.operand_a, req_ch.operand_b);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.result, rsp_ch.sign_of_a);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off so the block fills.
   initial begin
      int stall_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic fpa_pkg::word_type pick_fixed();
      fpa_pkg::word_type v;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 5))
               0: v = 32'h0000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h8000_0000;
               3: v = 32'hFFFF_FFFF;
               4: v = 32'h0001_0000;
               default: v = 32'hFFFF_0000;
            endcase
         end
         1: begin
            v = $urandom_range(0, 32'h00FF_FFFF);
            if ($urandom_range(0, 1)) v = ~v + 1;
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // Mostly floats whose exponent lands near the fixed-point range.
   function automatic fpa_pkg::word_type pick_float();
      fpa_pkg::word_type v;
      logic [7:0]        expo;
      if ($urandom_range(0, 4) == 0) return $urandom();
      case ($urandom_range(0, 9))
         0: expo = 8'd0;
         1: expo = 8'd255;
         default: expo = 8'($urandom_range(100, 160));
      endcase
      v = $urandom();
      v[30:23] = expo;
      return v;
   endfunction

   // Entered and left at a falling edge; holds the item until it is taken.
   task automatic send_item(input logic [fpa_pkg::OPCODE_W-1:0] op,
                            input fpa_pkg::word_type a, input fpa_pkg::word_type b);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.opcode = op;
      req_ch.operand_a = a;
      req_ch.operand_b = b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   initial begin
      logic [fpa_pkg::OPCODE_W-1:0] op;
      board = new();
      reset = 1'b1;
      idling = 1'b1;
      hold_request = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.opcode = fpa_pkg::OP_NEG;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(fpa_pkg::OP_NEG, 32'h0000_0000, 32'h0);
      send_item(fpa_pkg::OP_NEG, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(fpa_pkg::OP_NEG, 32'h7FFF_FFFF, 32'h0);
      send_item(fpa_pkg::OP_ABS, 32'hFFFF_0000, 32'h0);
      send_item(fpa_pkg::OP_ABS, 32'h8000_0000, 32'h0);
      send_item(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      send_item(fpa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(fpa_pkg::OP_MUL, 32'h0001_0000, 32'hFFFF_0000);
      send_item(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_item(fpa_pkg::OP_MUL, 32'h0000_0001, 32'hFFFF_FFFF);
      // Float inputs: zeros, a subnormal, minus one, Inf, NaN, wrap and shift-out.
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h0000_0000, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h8000_0000, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h0000_0001, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'hBF80_0000, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h7F80_0000, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'hFFC0_0000, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h4EFF_FFFF, 32'h0);
      send_item(fpa_pkg::OP_FROM_FLOAT, 32'h4F80_0000, 32'h0);
      send_item(fpa_pkg::OP_TO_FLOAT, 32'h0000_0000, 32'h0);
      send_item(fpa_pkg::OP_TO_FLOAT, 32'h0000_0001, 32'h0);
      send_item(fpa_pkg::OP_TO_FLOAT, 32'h8000_0000, 32'h0);
      send_item(fpa_pkg::OP_TO_FLOAT, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_SPARE_LO, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_SPARE_HI, 32'h1234_5678, 32'h0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PRESSURE_AT) hold_request <= 1'b1;
         if (i == QUIET_FROM) idling <= 1'b0;
         op = fpa_pkg::OPCODE_W'($urandom_range(0, OP_CODES - 1));
         send_item(op, (op == fpa_pkg::OP_FROM_FLOAT) ? pick_float() : pick_fixed(),
                   pick_fixed());
      end
      req_ch.valid = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: neg %0d, abs %0d, add %0d, mul %0d, float-in %0d,",
               board.items_seen, board.op_count[fpa_pkg::OP_NEG],
               board.op_count[fpa_pkg::OP_ABS], board.op_count[fpa_pkg::OP_ADD],
               board.op_count[fpa_pkg::OP_MUL], board.op_count[fpa_pkg::OP_FROM_FLOAT]);
      $display("float-out %0d, spare opcodes %0d; %0d results compared, %0d mismatches.",
               board.op_count[fpa_pkg::OP_TO_FLOAT],
               board.op_count[OP_SPARE_LO] + board.op_count[OP_SPARE_HI],
               board.compared, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
design/fpa_pkg.sv
design/fpa_req_if.sv
design/fpa_rsp_if.sv
design/fpa_arith.sv
design/fpa_conv.sv
design/fixed_point_alu_with_float_convert.sv
sim/testbench.sv
